>>> rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the checksummed packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

	localparam int ByteW  = 8;
	localparam int TypeW  = 16;
	localparam int LenW   = 6;
	localparam int CfgIdxW = 1;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_HEADER = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_FOOTER = 1'b1;

	localparam logic [ByteW-1:0] HeaderReset = 8'hAA;
	localparam logic [ByteW-1:0] FooterReset = 8'h55;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_LENGTH,
		ST_TYPE,
		ST_DATA,
		ST_CHECK,
		ST_FOOTER,
		ST_DRAIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic ld_len;       // length byte accepted and in range
		logic step_type;    // type byte accepted
		logic step_data;    // payload byte accepted
		logic start_drain;  // good footer, deliver the frame
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_header;
		logic len_ok;
		logic type_done;
		logic len_zero;
		logic data_done;
		logic sum_ok;
		logic footer_ok;
		logic drain_done;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/checksummed_packet_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_packet_deframer
// Byte stream in, frames out: header, length, type (2 bytes, big endian),
// payload, 8-bit additive checksum, footer.
//
// Usage:
//  - s_* takes one received byte per transaction. Outside a drain it is
//    ready every cycle; a frame of n payload bytes is n+6 input bytes.
//  - A frame with a bad length, checksum or footer is dropped silently and
//    the parser goes back to searching for the header byte.
//  - After a good footer, s_tready drops for the drain: max(n,1) payload
//    memory reads, one per cycle while m_tready keeps results moving.
//    Results pass the memory read stage, then the output register, to m_*.
//  - An empty frame gives one result with has_payload low and tlast high.
//  - If m_tready is low, the read stage and output register fill and the
//    drain pauses; once the drain has issued its last read, input is taken
//    again even if results still wait.
//  - cfg_* writes header/footer bytes; write only between frames.
//  - arst_n clears the parser to header search and drops m_tvalid; the
//    payload memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_packet_deframer
	import cpd_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [ByteW-1:0]   cfg_data,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // rx_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// packet_type[15:0], payload_length[21:16], payload_byte[29:22],
	// byte_index[35:30], zero[39:36]
	output logic [39:0]             m_tdata,
	output logic                    m_tuser,   // has_payload
	output logic                    m_tlast
);

	cmd_t             cmd;
	sts_t             sts;
	logic [TypeW-1:0] out_type;
	logic [LenW-1:0]  out_len, out_idx;
	logic [ByteW-1:0] out_byte;

	cpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpd_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_type  (out_type),
		.out_len   (out_len),
		.out_byte  (out_byte),
		.out_idx   (out_idx),
		.out_has   (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0000, out_idx, out_byte, out_len, out_type};

endmodule

`default_nettype wire

>>> rtl/cpd_ctrl.sv
// ----------------------------------------------------------------------------
// cpd_ctrl
// Frame parser state machine: walks header, length, type, payload, checksum
// and footer, then holds the input off while the datapath drains the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_ctrl
	import cpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = (state_q != ST_DRAIN);
		acc      = s_tvalid && s_tready;
		case (state_q)
			ST_LENGTH: begin
				if (acc) begin
					if (sts.len_ok) begin
						cmd.ld_len = 1'b1;
						state_d    = ST_TYPE;
					end else begin
						state_d = ST_HEADER;
					end
				end
			end
			ST_TYPE: begin
				if (acc) begin
					cmd.step_type = 1'b1;
					if (sts.type_done) begin
						state_d = sts.len_zero ? ST_CHECK : ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.step_data = 1'b1;
					if (sts.data_done) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (acc) begin
					state_d = sts.sum_ok ? ST_FOOTER : ST_HEADER;
				end
			end
			ST_FOOTER: begin
				if (acc) begin
					if (sts.footer_ok) begin
						cmd.start_drain = 1'b1;
						state_d         = ST_DRAIN;
					end else begin
						state_d = ST_HEADER;
					end
				end
			end
			ST_DRAIN: begin
				if (sts.drain_done) begin
					state_d = ST_HEADER;
				end
			end
			default: begin
				// header search, also taken by unused codes
				if (acc) begin
					state_d = sts.is_header ? ST_LENGTH : ST_HEADER;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/cpd_dp.sv
// ----------------------------------------------------------------------------
// cpd_dp
// Deframer datapath: config registers, length/type/checksum registers,
// payload memory and the drain pipeline (read stage, output register).
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_dp
	import cpd_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [ByteW-1:0]   cfg_data,
	input  wire logic [ByteW-1:0]   rx_byte,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TypeW-1:0]        out_type,
	output logic [LenW-1:0]         out_len,
	output logic [ByteW-1:0]        out_byte,
	output logic [LenW-1:0]         out_idx,
	output logic                    out_has,
	output logic                    out_last
);

	localparam int AW = $clog2(MAX_LEN);

	logic [ByteW-1:0] hdr_q, ftr_q;
	logic [LenW-1:0]  len_q, cnt_q, rd_q;
	logic [TypeW-1:0] type_q;
	logic [ByteW-1:0] sum_q;
	logic             draining_q;

	logic [ByteW-1:0] mem_q [MAX_LEN];
	logic [ByteW-1:0] rdata_q;

	// read stage
	logic             valid_s1;
	logic [TypeW-1:0] type_s1;
	logic [LenW-1:0]  len_s1, idx_s1;
	logic             has_s1, last_s1;

	logic out_load, slot_free, issue, last_issue, len_zero;

	assign len_zero   = (len_q == '0);
	assign out_load   = valid_s1 && (!m_tvalid || m_tready);
	assign slot_free  = !valid_s1 || out_load;
	assign issue      = draining_q && slot_free;
	assign last_issue = len_zero || (LenW'(rd_q + 1'b1) == len_q);

	always_comb begin
		sts.is_header  = (rx_byte == hdr_q);
		sts.len_ok     = ({1'b0, rx_byte} < 9'(MAX_LEN));
		sts.type_done  = (cnt_q == LenW'(1));
		sts.len_zero   = len_zero;
		sts.data_done  = (LenW'(cnt_q + 1'b1) == len_q);
		sts.sum_ok     = (rx_byte == sum_q);
		sts.footer_ok  = (rx_byte == ftr_q);
		sts.drain_done = issue && last_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HeaderReset;
			ftr_q <= FooterReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: hdr_q <= cfg_data;
				REG_FOOTER: ftr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			cnt_q  <= '0;
			type_q <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.ld_len) begin
				len_q  <= rx_byte[LenW-1:0];
				cnt_q  <= LenW'(2);
				type_q <= '0;
				sum_q  <= rx_byte;
			end
			if (cmd.step_type) begin
				sum_q  <= sum_q + rx_byte;
				type_q <= {type_q[ByteW-1:0], rx_byte};
				cnt_q  <= LenW'(cnt_q - 1'b1);
			end
			if (cmd.step_data) begin
				sum_q <= sum_q + rx_byte;
				cnt_q <= LenW'(cnt_q + 1'b1);
			end
		end
	end

	// payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.step_data) begin
			mem_q[cnt_q[AW-1:0]] <= rx_byte;
		end
		if (issue) begin
			rdata_q <= mem_q[rd_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			rd_q       <= '0;
		end else if (cmd.start_drain) begin
			draining_q <= 1'b1;
			rd_q       <= '0;
		end else if (issue) begin
			rd_q <= LenW'(rd_q + 1'b1);
			if (last_issue) begin
				draining_q <= 1'b0;
			end
		end
	end

	// type and length travel with each result so the next frame can load
	// its own while results still wait downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			type_s1 <= type_q;
			len_s1  <= len_q;
			idx_s1  <= rd_q;
			has_s1  <= !len_zero;
			last_s1 <= last_issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_type <= type_s1;
			out_len  <= len_s1;
			out_byte <= has_s1 ? rdata_q : '0;
			out_idx  <= idx_s1;
			out_has  <= has_s1;
			out_last <= last_s1;
		end
	end

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		sts.drain_done |=> !draining_q)
		else $error("drain still active after last read");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_data |-> !draining_q)
		else $error("payload written while draining");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (len_zero || rd_q < len_q))
		else $error("drain read beyond frame length");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !issue)
		else $error("read issued into a full stage");

endmodule

`default_nettype wire
